// File: design/xsrf_pkg.sv
// Shared types and codes for the x86 shift and rotate flags unit.
package xsrf_pkg;

  localparam logic [2:0] MODE_SHL = 3'd0;
  localparam logic [2:0] MODE_SHR = 3'd1;
  localparam logic [2:0] MODE_SAR = 3'd2;
  localparam logic [2:0] MODE_ROL = 3'd3;
  localparam logic [2:0] MODE_ROR = 3'd4;
  localparam logic [2:0] MODE_RCL = 3'd5;
  localparam logic [2:0] MODE_RCR = 3'd6;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  localparam logic [7:0] COUNT_MASK_32 = 8'h1f;
  localparam logic [7:0] COUNT_MASK_64 = 8'h3f;

  localparam int UNDEF_CF_BIT = 0;
  localparam int UNDEF_OF_BIT = 1;
  localparam int UNDEF_AF_BIT = 2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  width_code;
    logic [63:0] operand_value;
    logic [7:0]  count;
    logic        cf;
    logic        of;
    logic        sf;
    logic        zf;
    logic        pf;
    logic        af;
  } xsrf_req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        cf;
    logic        of;
    logic        sf;
    logic        zf;
    logic        pf;
    logic        af;
    logic [2:0]  undefined_mask;
  } xsrf_res_t;

endpackage

// File: design/x86_shift_rotate_flags_core.sv
// Top level of the x86 shift and rotate flags unit.
//
// This unit executes one x86 SHL/SAL, SHR, SAR, ROL, ROR, RCL or RCR per
// request on an 8, 16, 32 or 64-bit operand and returns the result with
// the updated CF, OF, SF, ZF, PF and AF. It accepts one request every
// clock cycle unless a stalled result register holds up the input
// register. A request is held in the input register while it passes
// through the shift, rotate and flag logic, and the result register then
// loads it and offers it to the consumer. The result register and the
// input register stall independently, so a new request is still taken
// while a finished result waits for the consumer, as long as the input
// register is free. Where a flag is treated as undefined, its old value
// is passed through and the matching bit of undefined_mask is set (bit 0
// CF, bit 1 OF, bit 2 AF). A zero count, after masking or after the
// modulo reduction of the through-carry rotates, returns the operand and
// leaves every flag alone. Mode seven is unused and simply passes the
// masked operand and flags.
module x86_shift_rotate_flags_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [1:0]  width_code,
  input  logic [63:0] operand_value,
  input  logic [7:0]  count,
  input  logic        cf_in,
  input  logic        of_in,
  input  logic        sf_in,
  input  logic        zf_in,
  input  logic        pf_in,
  input  logic        af_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_value,
  output logic        cf_out,
  output logic        of_out,
  output logic        sf_out,
  output logic        zf_out,
  output logic        pf_out,
  output logic        af_out,
  output logic [2:0]  undefined_mask
);
  import xsrf_pkg::*;

  logic      s1_valid;
  xsrf_req_t s1_req;
  xsrf_res_t exec_res;
  xsrf_res_t out_res;
  logic      s1_adv;

  // The result register can load whenever it is empty or being drained,
  // and the input register can load whenever it is empty or its request moves on.
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers carry no reset; they load only with a live request.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req.mode          <= mode;
      s1_req.width_code    <= width_code;
      s1_req.operand_value <= operand_value;
      s1_req.count         <= count;
      s1_req.cf            <= cf_in;
      s1_req.of            <= of_in;
      s1_req.sf            <= sf_in;
      s1_req.zf            <= zf_in;
      s1_req.pf            <= pf_in;
      s1_req.af            <= af_in;
    end
    if (s1_valid && s1_adv) begin
      out_res <= exec_res;
    end
  end

  xsrf_exec u_exec (
    .req (s1_req),
    .res (exec_res)
  );

  assign result_value   = out_res.result_value;
  assign cf_out         = out_res.cf;
  assign of_out         = out_res.of;
  assign sf_out         = out_res.sf;
  assign zf_out         = out_res.zf;
  assign pf_out         = out_res.pf;
  assign af_out         = out_res.af;
  assign undefined_mask = out_res.undefined_mask;

endmodule

// File: design/xsrf_exec.sv
// Combinational shift, rotate and flag logic for one request.
module xsrf_exec (
  input  xsrf_pkg::xsrf_req_t req,
  output xsrf_pkg::xsrf_res_t res
);
  import xsrf_pkg::*;

  logic [6:0]   wbits;
  logic [63:0]  wmask;
  logic [63:0]  x;
  logic [5:0]   cnt;
  logic [5:0]   rcnt;
  logic [6:0]   rc;
  logic         x_top;
  logic [127:0] shl_ext;
  logic         fill;
  logic [63:0]  sr_src;
  logic [128:0] sr_ext;
  logic [127:0] rep;
  logic [127:0] rol_ext;
  logic [127:0] ror_ext;
  logic [64:0]  y;
  logic [64:0]  rcl_val;
  logic [64:0]  rcr_val;
  logic [6:0]   rc_back;
  logic [63:0]  r_val;

  function automatic logic top_of(input logic [63:0] v, input logic [1:0] wc);
    logic b;
    case (wc)
      WIDTH_8:  b = v[7];
      WIDTH_16: b = v[15];
      WIDTH_32: b = v[31];
      default:  b = v[63];
    endcase
    return b;
  endfunction

  function automatic logic next_of(input logic [63:0] v, input logic [1:0] wc);
    logic b;
    case (wc)
      WIDTH_8:  b = v[6];
      WIDTH_16: b = v[14];
      WIDTH_32: b = v[30];
      default:  b = v[62];
    endcase
    return b;
  endfunction

  always_comb begin
    case (req.width_code)
      WIDTH_8: begin
        wbits = 7'd8;
        wmask = 64'h0000_0000_0000_00ff;
      end
      WIDTH_16: begin
        wbits = 7'd16;
        wmask = 64'h0000_0000_0000_ffff;
      end
      WIDTH_32: begin
        wbits = 7'd32;
        wmask = 64'h0000_0000_ffff_ffff;
      end
      default: begin
        wbits = 7'd64;
        wmask = 64'hffff_ffff_ffff_ffff;
      end
    endcase
  end

  assign x     = req.operand_value & wmask;
  assign cnt   = (req.width_code == WIDTH_64) ? 6'(req.count & COUNT_MASK_64)
                                              : 6'(req.count & COUNT_MASK_32);
  assign rcnt  = cnt & 6'(wbits - 7'd1);
  assign x_top = top_of(x, req.width_code);

  // Through-carry rotates reduce the count modulo width plus one.
  always_comb begin
    case (req.width_code)
      WIDTH_8: begin
        if (cnt >= 6'd27) rc = 7'(cnt - 6'd27);
        else if (cnt >= 6'd18) rc = 7'(cnt - 6'd18);
        else if (cnt >= 6'd9) rc = 7'(cnt - 6'd9);
        else rc = 7'(cnt);
      end
      WIDTH_16: begin
        if (cnt >= 6'd17) rc = 7'(cnt - 6'd17);
        else rc = 7'(cnt);
      end
      default: rc = 7'(cnt);
    endcase
  end

  // Left shift: the bit at position width is the last one shifted out.
  assign shl_ext = {64'd0, x} << cnt;

  // Right shifts share one arithmetic shifter; only SAR fills with the sign.
  assign fill    = (req.mode == MODE_SAR) && x_top;
  assign sr_src  = fill ? (x | ~wmask) : x;
  assign sr_ext  = $unsigned($signed({fill, sr_src, 64'd0}) >>> cnt);

  always_comb begin
    case (req.width_code)
      WIDTH_8:  rep = {16{x[7:0]}};
      WIDTH_16: rep = {8{x[15:0]}};
      WIDTH_32: rep = {4{x[31:0]}};
      default:  rep = {2{x}};
    endcase
  end

  assign rol_ext = rep << rcnt;
  assign ror_ext = rep >> rcnt;

  always_comb begin
    y = {1'b0, x};
    y[wbits] = req.cf;
  end

  assign rc_back = 7'(wbits + 7'd1 - rc);
  assign rcl_val = (y << rc) | (y >> rc_back);
  assign rcr_val = (y >> rc) | (y << rc_back);

  always_comb begin
    r_val                = x;
    res.cf               = req.cf;
    res.of               = req.of;
    res.sf               = req.sf;
    res.zf               = req.zf;
    res.pf               = req.pf;
    res.af               = req.af;
    res.undefined_mask   = 3'd0;
    case (req.mode)
      MODE_SHL, MODE_SHR, MODE_SAR: begin
        if (cnt != 6'd0) begin
          if (req.mode == MODE_SHL) begin
            r_val = shl_ext[63:0] & wmask;
          end else begin
            r_val = sr_ext[127:64] & wmask;
          end
          if ((req.mode != MODE_SAR) && (7'(cnt) >= wbits)) begin
            res.undefined_mask[UNDEF_CF_BIT] = 1'b1;
          end else if (req.mode == MODE_SHL) begin
            res.cf = shl_ext[wbits];
          end else begin
            res.cf = sr_ext[63];
          end
          if (cnt == 6'd1) begin
            if (req.mode == MODE_SHL) begin
              res.of = top_of(r_val, req.width_code) ^ shl_ext[wbits];
            end else if (req.mode == MODE_SHR) begin
              res.of = x_top;
            end else begin
              res.of = 1'b0;
            end
          end
          res.sf = top_of(r_val, req.width_code);
          res.zf = (r_val == 64'd0);
          res.pf = ~^r_val[7:0];
          res.undefined_mask[UNDEF_AF_BIT] = 1'b1;
        end
      end
      MODE_ROL, MODE_ROR: begin
        if (cnt != 6'd0) begin
          if (req.mode == MODE_ROL) begin
            r_val  = rol_ext[127:64] & wmask;
            res.cf = r_val[0];
            if (cnt == 6'd1) begin
              res.of = top_of(r_val, req.width_code) ^ r_val[0];
            end
          end else begin
            r_val  = ror_ext[63:0] & wmask;
            res.cf = top_of(r_val, req.width_code);
            if (cnt == 6'd1) begin
              res.of = top_of(r_val, req.width_code) ^ next_of(r_val, req.width_code);
            end
          end
          if (cnt > 6'd1) begin
            res.undefined_mask[UNDEF_OF_BIT] = 1'b1;
          end
        end
      end
      MODE_RCL, MODE_RCR: begin
        if (rc != 7'd0) begin
          if (req.mode == MODE_RCL) begin
            r_val  = rcl_val[63:0] & wmask;
            res.cf = rcl_val[wbits];
            if (rc == 7'd1) begin
              res.of = rcl_val[wbits] ^ top_of(r_val, req.width_code);
            end
          end else begin
            r_val  = rcr_val[63:0] & wmask;
            res.cf = rcr_val[wbits];
            if (rc == 7'd1) begin
              res.of = top_of(r_val, req.width_code) ^ next_of(r_val, req.width_code);
            end
          end
          if (rc > 7'd1) begin
            res.undefined_mask[UNDEF_OF_BIT] = 1'b1;
          end
        end
      end
      default: begin
        r_val = x;
      end
    endcase
    res.result_value = r_val;
  end

endmodule
